FILE: rtl/olir_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ordered list block
// no dependencies

package olir_pkg;

    localparam int OP_W   = 2;
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic                     clr;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

FILE: rtl/olir_cell.sv
`timescale 1ns / 1ps
// one list slot: holds an entry and moves it to or from its neighbors
// depends on olir_pkg

module olir_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  olir_pkg::cell_ctl_t               ctl,
    input  logic signed [olir_pkg::DATA_W-1:0] left_data,
    input  logic signed [olir_pkg::DATA_W-1:0] right_data,
    output logic signed [olir_pkg::DATA_W-1:0] data
);

    logic signed [olir_pkg::DATA_W-1:0] entry_reg;
    logic signed [olir_pkg::DATA_W-1:0] entry_next;
    logic                               at_pos;
    logic                               above_pos;

    assign at_pos    = (32'(IDX) == 32'(ctl.pos));
    assign above_pos = (32'(IDX) > 32'(ctl.pos));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.clr)
        begin
            entry_next = '0;
        end
        else if (ctl.ins)
        begin
            if (at_pos)
            begin
                entry_next = ctl.value;
            end
            else if (above_pos)
            begin
                entry_next = left_data;
            end
        end
        else if (ctl.rem)
        begin
            if (at_pos || above_pos)
            begin
                entry_next = right_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign data = entry_reg;

endmodule

FILE: rtl/ordered_list_insert_remove.sv
`timescale 1ns / 1ps
// ordered list with positional insert and remove over a chain of slot cells
// results sit in an output register; insert/remove shift slots >= pos at once
// throughput: one beat per cycle unless m_axis_tready stalls the output
// reset: all entries zero, length zero, no result pending
// depends on olir_pkg and olir_cell

module ordered_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation[1:0], position[5:2], value[37:6], zero[39:38]
    input  logic [olir_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], read_value[33:2], length[38:34], is_full[39]
    output logic [olir_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;
    localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

    logic [olir_pkg::OP_W-1:0]          op;
    logic [olir_pkg::POS_W-1:0]         pos;
    logic signed [olir_pkg::DATA_W-1:0] val;
    logic                               accept;

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [CMPW-1:0]                    cnt_ext;
    logic [CMPW-1:0]                    pos_ext;
    logic                               list_full;

    logic [olir_pkg::ST_W-1:0]          status;
    logic signed [olir_pkg::DATA_W-1:0] rd;
    logic signed [olir_pkg::DATA_W-1:0] rd_sel;
    olir_pkg::cell_ctl_t                ctl;

    logic                               out_valid_reg;
    logic [olir_pkg::ST_W-1:0]          status_reg;
    logic signed [olir_pkg::DATA_W-1:0] rd_reg;
    logic [olir_pkg::LEN_W-1:0]         len_reg;
    logic                               full_reg;

    logic signed [olir_pkg::DATA_W-1:0] cell_data [CAPACITY];

    assign op  = s_axis_tdata[1:0];
    assign pos = s_axis_tdata[5:2];
    assign val = s_axis_tdata[37:6];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cnt_ext   = CMPW'(count_reg);
    assign pos_ext   = CMPW'(pos);
    assign list_full = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        rd_sel = '0;
        for (int k = 0; k < RD_N; k++)
        begin
            if (pos == olir_pkg::POS_W'(k))
            begin
                rd_sel = cell_data[k];
            end
        end
    end

    always_comb
    begin
        status     = olir_pkg::ST_DONE;
        rd         = '0;
        count_next = count_reg;
        ctl.ins    = 1'b0;
        ctl.rem    = 1'b0;
        ctl.clr    = 1'b0;
        ctl.pos    = pos;
        ctl.value  = val;
        case (op)
            olir_pkg::OP_INSERT:
            begin
                if (list_full)
                begin
                    status = olir_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status = olir_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.ins    = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            olir_pkg::OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status = olir_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.rem    = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            olir_pkg::OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status = olir_pkg::ST_RANGE;
                end
                else
                begin
                    rd = rd_sel;
                end
            end
            default:
            begin
                ctl.clr    = accept;
                count_next = '0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [olir_pkg::DATA_W-1:0] left_d;
            logic signed [olir_pkg::DATA_W-1:0] right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            olir_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            rd_reg     <= rd;
            len_reg    <= olir_pkg::LEN_W'(count_next);
            full_reg   <= (count_next == CW'(CAPACITY));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {full_reg, len_reg, rd_reg, status_reg};

endmodule
